/* hdl/strmq_pkg.sv */
// ----------------------------------------------------------------------------
// strmq_pkg - shared types and constants for the sparse table RMQ unit
// Widths, table geometry, action codes, signed min and floor log2 helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package strmq_pkg;

    // geometry
    localparam int WORD_W    = 64;
    localparam int IDX_W     = 8;
    localparam int LVL_W     = 4;
    localparam int ROW_DEPTH = 256;
    localparam int TOP_LEVEL = 8;
    localparam int TBL_DEPTH = (TOP_LEVEL + 1) * ROW_DEPTH;
    localparam int TADDR_W   = LVL_W + IDX_W;

    // action codes
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_BUILD = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;
    localparam logic [1:0] ACT_NOP   = 2'd3;

    localparam logic [IDX_W-1:0] LAST_RESET = 8'd255;

    // answer for an empty range (1e18)
    localparam logic signed [WORD_W-1:0] EMPTY_ANSWER = 64'sd1000000000000000000;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [LVL_W-1:0]         t_lvl;
    typedef logic [TADDR_W-1:0]       t_taddr;

    // table memory access request
    typedef struct packed {
        logic   wr_en;
        t_taddr wr_addr;
        logic   rd_en;
        t_taddr rd_addr_a;
        t_taddr rd_addr_b;
    } t_tbl_req;

    // signed minimum
    function automatic t_word smin(input t_word a, input t_word b);
        smin = (a <= b) ? a : b;
    endfunction

    // floor(log2(x)) for a nonzero 9-bit value, 0 for x <= 1
    function automatic t_lvl floor_log2(input logic [8:0] x);
        t_lvl r;
        r = '0;
        for (int b = 1; b < 9; b++) begin
            if (x[b]) r = LVL_W'(b);
        end
        floor_log2 = r;
    endfunction

endpackage

`default_nettype wire

/* hdl/strmq_base_mem.sv */
// ----------------------------------------------------------------------------
// strmq_base_mem - base array storage
// 256 x 64 memory, one write and one registered read port. A per-entry valid
// bit, cleared at reset, makes never-written entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module strmq_base_mem (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_wr_en,
    input  wire strmq_pkg::t_idx  i_wr_addr,
    input  wire strmq_pkg::t_word i_wr_data,
    input  wire                   i_rd_en,
    input  wire strmq_pkg::t_idx  i_rd_addr,
    output strmq_pkg::t_word      o_rd_data
);

    strmq_pkg::t_word                      r_mem [0:strmq_pkg::ROW_DEPTH-1];
    logic [strmq_pkg::ROW_DEPTH-1:0]       r_valid;
    strmq_pkg::t_word                      r_rd_data;
    logic                                  r_rd_valid;

    // storage and read register
    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
        if (i_rd_en) r_rd_data <= r_mem[i_rd_addr];
    end

    // entry valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) r_valid[i_wr_addr] <= 1'b1;
            if (i_rd_en) r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

/* hdl/strmq_table_mem.sv */
// ----------------------------------------------------------------------------
// strmq_table_mem - sparse table storage
// 2304 x 64 memory (9 levels of 256), one write and two registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module strmq_table_mem (
    input  wire                      i_clk,
    input  wire strmq_pkg::t_tbl_req i_req,
    input  wire strmq_pkg::t_word    i_wr_data,
    output strmq_pkg::t_word         o_rd_a,
    output strmq_pkg::t_word         o_rd_b
);

    strmq_pkg::t_word r_mem [0:strmq_pkg::TBL_DEPTH-1];
    strmq_pkg::t_word r_rd_a;
    strmq_pkg::t_word r_rd_b;

    // one write, two reads per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) r_mem[i_req.wr_addr] <= i_wr_data;
        if (i_req.rd_en) begin
            r_rd_a <= r_mem[i_req.rd_addr_a];
            r_rd_b <= r_mem[i_req.rd_addr_b];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

`default_nettype wire

/* hdl/sparse_table_range_minimum_unit.sv */
// ----------------------------------------------------------------------------
// sparse_table_range_minimum_unit - range minimum engine on a sparse table
// Command port: a beat is taken when start is high and busy is low.
//   write (action 0): stores value at index in the base array.
//   build (action 1): copies the base array to level 0 and fills levels
//     1..floor(log2(last_index+1)); each level k writes (last_index+2-2^k)
//     entries through the single table write port, then a drain state
//     lets the last write land. Full size build: 1802 table writes.
//   query (action 2): the beat moves the unit to QADDR, where both table
//     reads are issued together; the result strobe o_valid is high in
//     QOUT, which comes after QADDR. Busy is high in QADDR but drops while
//     the result is shown, so a new beat can be taken in QOUT.
//   action 3 is taken and ignored.
// Only queries produce a result, one cycle wide; the receiver cannot stall.
// last_index is written through i_cfg_we / i_cfg_wdata; the user must write it
// only while idle, the unit does not enforce this. Reset: last_index returns
// to 255, the base array reads as zero, the table holds nothing until a build.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_table_range_minimum_unit (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire         [7:0]  i_cfg_wdata,
    input  wire                start,
    output logic               busy,
    input  wire         [1:0]  i_action,
    input  wire         [7:0]  i_index,
    input  wire signed  [63:0] i_value,
    input  wire signed  [10:0] i_left,
    input  wire signed  [10:0] i_right,
    output logic               o_valid,
    output logic signed [63:0] o_minimum,
    output logic               o_empty_range
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_BRUN   = 3'd1;
    localparam logic [2:0] ST_BDRAIN = 3'd2;
    localparam logic [2:0] ST_QADDR  = 3'd3;
    localparam logic [2:0] ST_QOUT   = 3'd4;

    logic [2:0]          r_state;
    strmq_pkg::t_idx     r_last_index;
    strmq_pkg::t_lvl     r_level;
    strmq_pkg::t_lvl     r_levels;
    strmq_pkg::t_idx     r_idx;
    logic [8:0]          r_last;
    logic signed [10:0]  r_left;
    logic signed [10:0]  r_right;
    logic                r_empty;
    logic                r_wr_vld;
    logic                r_wr_lvl0;
    strmq_pkg::t_taddr   r_wr_addr;

    logic                accept;
    strmq_pkg::t_word    base_rd;
    strmq_pkg::t_word    tbl_rd_a;
    strmq_pkg::t_word    tbl_rd_b;
    strmq_pkg::t_word    pair_min;
    strmq_pkg::t_tbl_req tbl_req;
    strmq_pkg::t_idx     half;
    strmq_pkg::t_lvl     lvl_prev;

    logic signed [10:0]  n_s;
    logic signed [10:0]  l_c;
    logic signed [10:0]  r_c;
    logic signed [10:0]  q_diff;
    logic                q_empty;
    logic [8:0]          q_len;
    strmq_pkg::t_lvl     q_p;
    logic [8:0]          q_second;

    assign busy   = (r_state != ST_IDLE) && (r_state != ST_QOUT);
    assign accept = start && !busy;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_index <= strmq_pkg::LAST_RESET;
        end else if (i_cfg_we) begin
            r_last_index <= i_cfg_wdata;
        end
    end

    // query address generation: clamp, length, level, second entry
    assign n_s      = $signed({3'b000, r_last_index});
    assign l_c      = r_left[10] ? 11'sd0 : r_left;
    assign r_c      = (r_right > n_s) ? n_s : r_right;
    assign q_empty  = l_c > r_c;
    assign q_diff   = r_c - l_c + 11'sd1;
    assign q_len    = q_diff[8:0];
    assign q_p      = strmq_pkg::floor_log2(q_len);
    assign q_second = {1'b0, r_c[7:0]} + 9'd1 - (9'd1 << q_p);

    // build addressing
    assign lvl_prev = r_level - 4'd1;
    assign half     = 8'(9'd1 << lvl_prev);

    // table memory request
    always_comb begin
        tbl_req.wr_en     = r_wr_vld;
        tbl_req.wr_addr   = r_wr_addr;
        tbl_req.rd_en     = 1'b0;
        tbl_req.rd_addr_a = {lvl_prev, r_idx};
        tbl_req.rd_addr_b = {lvl_prev, r_idx + half};
        unique case (r_state)
            ST_BRUN: begin
                tbl_req.rd_en = (r_level != 4'd0);
            end
            ST_QADDR: begin
                tbl_req.rd_en     = 1'b1;
                tbl_req.rd_addr_a = {q_p, l_c[7:0]};
                tbl_req.rd_addr_b = {q_p, q_second[7:0]};
            end
            default: begin
                tbl_req.rd_en = 1'b0;
            end
        endcase
    end

    assign pair_min = strmq_pkg::smin(tbl_rd_a, tbl_rd_b);

    strmq_base_mem u_base_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (accept && (i_action == strmq_pkg::ACT_WRITE)),
        .i_wr_addr (i_index),
        .i_wr_data (i_value),
        .i_rd_en   ((r_state == ST_BRUN) && (r_level == 4'd0)),
        .i_rd_addr (r_idx),
        .o_rd_data (base_rd)
    );

    strmq_table_mem u_table_mem (
        .i_clk     (i_clk),
        .i_req     (tbl_req),
        .i_wr_data (r_wr_lvl0 ? base_rd : pair_min),
        .o_rd_a    (tbl_rd_a),
        .o_rd_b    (tbl_rd_b)
    );

    // build write pipeline: read this cycle, write the next
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_vld <= 1'b0;
        end else begin
            r_wr_vld <= (r_state == ST_BRUN);
        end
        r_wr_lvl0 <= (r_level == 4'd0);
        r_wr_addr <= {r_level, r_idx};
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE, ST_QOUT: begin
                    r_state <= ST_IDLE;
                    if (accept) begin
                        unique case (i_action)
                            strmq_pkg::ACT_BUILD: r_state <= ST_BRUN;
                            strmq_pkg::ACT_QUERY: r_state <= ST_QADDR;
                            default:              r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_BRUN: begin
                    if (r_idx == r_last[7:0]) r_state <= ST_BDRAIN;
                end
                ST_BDRAIN: begin
                    r_state <= (r_level == r_levels) ? ST_IDLE : ST_BRUN;
                end
                ST_QADDR: begin
                    r_state <= ST_QOUT;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // build counters and query operands
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE, ST_QOUT: begin
                if (accept) begin
                    r_level  <= '0;
                    r_idx    <= '0;
                    r_last   <= {1'b0, r_last_index};
                    r_levels <= strmq_pkg::floor_log2({1'b0, r_last_index} + 9'd1);
                    r_left   <= i_left;
                    r_right  <= i_right;
                end
            end
            ST_BRUN: begin
                r_idx <= r_idx + 8'd1;
            end
            ST_BDRAIN: begin
                r_level <= r_level + 4'd1;
                r_idx   <= '0;
                r_last  <= {1'b0, r_last_index} + 9'd1 - (9'd1 << (r_level + 4'd1));
            end
            ST_QADDR: begin
                r_empty <= q_empty;
            end
            default: begin
                r_idx <= '0;
            end
        endcase
    end

    // result beat
    assign o_valid       = (r_state == ST_QOUT);
    assign o_empty_range = r_empty;
    assign o_minimum     = r_empty ? strmq_pkg::EMPTY_ANSWER : pair_min;

endmodule

`default_nettype wire

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb - self-checking bench for sparse_table_range_minimum_unit
// Feeds write, build, query and no-op command beats through the start/busy
// port with random gaps, keeps its own copy of the base array and the
// sparse levels, and checks every query answer in order against it. The
// last_index register is changed between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 1000000;
    // long enough for a full size build to finish
    localparam int BUILD_DRAIN = 2200;
    localparam int REPORT_MAX  = 10;

    typedef struct {
        logic [1:0]         action;
        logic [7:0]         index;
        logic signed [63:0] value;
        logic signed [10:0] lo_bound;
        logic signed [10:0] hi_bound;
        bit                 hold;      // present only once all answers are in
    } t_rmq_cmd;

    typedef struct {
        logic signed [63:0] minimum;
        logic               is_empty;
    } t_rmq_answer;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [7:0]         i_cfg_wdata   = 8'd0;
    logic               start         = 1'b0;
    logic [1:0]         i_action      = strmq_pkg::ACT_NOP;
    logic [7:0]         i_index       = 8'd0;
    logic signed [63:0] i_value       = 64'sd0;
    logic signed [10:0] i_left        = 11'sd0;
    logic signed [10:0] i_right       = 11'sd0;
    wire                busy;
    wire                o_valid;
    wire signed  [63:0] o_minimum;
    wire                o_empty_range;

    sparse_table_range_minimum_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_index       (i_index),
        .i_value       (i_value),
        .i_left        (i_left),
        .i_right       (i_right),
        .o_valid       (o_valid),
        .o_minimum     (o_minimum),
        .o_empty_range (o_empty_range)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    t_rmq_cmd           pending_cmds[$];
    t_rmq_answer        answers_due[$];
    logic signed [63:0] base_mem [0:strmq_pkg::ROW_DEPTH-1];
    logic signed [63:0] lvl_mem  [0:strmq_pkg::TOP_LEVEL][0:strmq_pkg::ROW_DEPTH-1];
    logic [7:0]         cfg_last    = strmq_pkg::LAST_RESET;
    logic               took        = 1'b0;
    bit                 idle_on     = 1'b1;
    int                 mismatches  = 0;
    int                 cycle_count = 0;
    int                 gap_left    = 0;
    int                 gen_n       = 255;
    int                 gen_built_n = -1;   // widest last_index built so far

    function automatic int floor_lg(input int x);
        int p;
        p = 0;
        while (x > 1) begin
            x = x >> 1;
            p++;
        end
        return p;
    endfunction

    function automatic logic signed [63:0] lesser(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        return (b < a) ? b : a;
    endfunction

    // refill level 0 from the base array and every level above it
    task automatic rebuild_levels();
        int n, top, k, i, half;
        n   = int'(cfg_last);
        top = floor_lg(n + 1);
        if (top > strmq_pkg::TOP_LEVEL) top = strmq_pkg::TOP_LEVEL;
        for (i = 0; i <= n; i++) lvl_mem[0][i] = base_mem[i];
        for (k = 1; k <= top; k++) begin
            half = 1 << (k - 1);
            for (i = 0; i + 2 * half <= n + 1; i++)
                lvl_mem[k][i] = lesser(lvl_mem[k-1][i], lvl_mem[k-1][i+half]);
        end
    endtask

    // answer of one query against the table as last built
    function automatic t_rmq_answer range_min(input logic signed [10:0] lo_raw,
                                              input logic signed [10:0] hi_raw);
        t_rmq_answer a;
        int lo, hi, p;
        lo = int'(lo_raw);
        hi = int'(hi_raw);
        if (lo < 0) lo = 0;
        if (hi > int'(cfg_last)) hi = int'(cfg_last);
        if (lo > hi) begin
            a.minimum  = strmq_pkg::EMPTY_ANSWER;
            a.is_empty = 1'b1;
        end else begin
            p = floor_lg(hi - lo + 1);
            if (p > strmq_pkg::TOP_LEVEL) p = strmq_pkg::TOP_LEVEL;
            a.minimum  = lesser(lvl_mem[p][lo], lvl_mem[p][hi - (1 << p) + 1]);
            a.is_empty = 1'b0;
        end
        return a;
    endfunction

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // driver: one beat held until taken, then an optional gap
    always @(negedge i_clk) begin
        t_rmq_cmd c;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || took) begin
            if (start) gap_left = next_gap();
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_cmds.size() > 0 &&
                         (!pending_cmds[0].hold || answers_due.size() == 0)) begin
                c = pending_cmds.pop_front();
                i_action <= c.action;
                i_index  <= c.index;
                i_value  <= c.value;
                i_left   <= c.lo_bound;
                i_right  <= c.hi_bound;
                start    <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: check answers, then fold each taken beat into the model
    always @(posedge i_clk) begin
        t_rmq_answer want;
        if (!i_rst_n) begin
            took <= 1'b0;
        end else begin
            took <= (start === 1'b1 && busy === 1'b0);
            if (o_valid !== 1'b0) begin
                if (answers_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("answer with no query waiting: min %0d empty %0b",
                                 o_minimum, o_empty_range);
                end else begin
                    want = answers_due.pop_front();
                    if (o_minimum !== want.minimum ||
                        o_empty_range !== want.is_empty) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("mismatch: exp min %0d empty %0b, got min %0d empty %0b",
                                     want.minimum, want.is_empty,
                                     o_minimum, o_empty_range);
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                case (i_action)
                    strmq_pkg::ACT_WRITE: base_mem[i_index] = i_value;
                    strmq_pkg::ACT_BUILD: rebuild_levels();
                    strmq_pkg::ACT_QUERY: answers_due.push_back(range_min(i_left, i_right));
                    default: ;
                endcase
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_cmd(input logic [1:0] act, input logic [7:0] idx,
                            input logic signed [63:0] val, input int lo, input int hi,
                            input bit hold);
        t_rmq_cmd c;
        c.action   = act;
        c.index    = idx;
        c.value    = val;
        c.lo_bound = 11'(lo);
        c.hi_bound = 11'(hi);
        c.hold     = hold;
        pending_cmds.push_back(c);
    endtask

    function automatic logic signed [63:0] pick_value();
        logic signed [63:0] v;
        int k;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            5, 6: begin
                k = int'($urandom_range(0, 16)) - 8;
                v = 64'(k);
            end
            7: begin
                k = $urandom;
                v = 64'(k);
            end
            8: begin
                case ($urandom_range(0, 3))
                    0: v = 64'sh8000_0000_0000_0000;
                    1: v = 64'sh7FFF_FFFF_FFFF_FFFF;
                    2: v = 64'sd0;
                    default: v = -64'sd1;
                endcase
            end
            default: ;
        endcase
        return v;
    endfunction

    // random mix: mostly writes and queries, a few builds and no-ops
    task automatic queue_random_cmds(input int count);
        t_rmq_cmd c, b;
        int r, lo, hi, made;
        made = 0;
        while (made < count) begin
            c.action   = strmq_pkg::ACT_NOP;
            c.index    = 8'($urandom);
            c.value    = pick_value();
            c.lo_bound = 11'($urandom);
            c.hi_bound = 11'($urandom);
            c.hold     = ($urandom_range(0, 99) == 0);
            r = $urandom_range(0, 99);
            if (r < 45) begin
                c.action = strmq_pkg::ACT_WRITE;
                if ($urandom_range(0, 9) < 7) c.index = 8'($urandom_range(0, gen_n));
            end else if (r < 92) begin
                // never read table entries that no build has written
                if (gen_built_n < gen_n) begin
                    b = c;
                    b.action = strmq_pkg::ACT_BUILD;
                    b.hold   = 1'b0;
                    pending_cmds.push_back(b);
                    gen_built_n = gen_n;
                    made++;
                end
                c.action = strmq_pkg::ACT_QUERY;
                lo = $urandom_range(0, gen_n);
                hi = $urandom_range(lo, gen_n);
                case ($urandom_range(0, 9))
                    5: hi = lo;
                    6: hi = lo + (1 << $urandom_range(0, floor_lg(gen_n + 1))) - 1;
                    7: begin
                        lo = -int'($urandom_range(0, 1024));
                        hi = $urandom_range(gen_n, 1023);
                    end
                    8: begin
                        lo = $urandom_range(0, 1023);
                        hi = lo - int'($urandom_range(1, 30));
                    end
                    default: ;
                endcase
                c.lo_bound = 11'(lo);
                c.hi_bound = 11'(hi);
                if ($urandom_range(0, 9) == 9) begin
                    c.lo_bound = 11'($urandom);
                    c.hi_bound = 11'($urandom);
                end
            end else if (r < 95) begin
                c.action = strmq_pkg::ACT_BUILD;
                if (gen_n > gen_built_n) gen_built_n = gen_n;
            end
            pending_cmds.push_back(c);
            made++;
        end
    endtask

    // drain everything, then give a trailing build time to finish
    task automatic wait_idle();
        while (pending_cmds.size() > 0 || start || answers_due.size() > 0)
            @(posedge i_clk);
        repeat (BUILD_DRAIN) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic load_last_index(input logic [7:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_last = v;
        gen_n    = int'(v);
    endtask

    // stimulus sequence
    initial begin
        int i, ph;
        int unsigned span_plan[10];
        span_plan = '{0, 1, 255, 7, 2, 63, 16, 200, 31, 5};
        for (i = 0; i < strmq_pkg::ROW_DEPTH; i++) base_mem[i] = 64'sd0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, clamping, empty ranges, stale table after write
        push_cmd(strmq_pkg::ACT_WRITE, 8'd0,   64'sh8000_0000_0000_0000, 0, 0, 0);
        push_cmd(strmq_pkg::ACT_WRITE, 8'd255, 64'sh7FFF_FFFF_FFFF_FFFF, 0, 0, 0);
        push_cmd(strmq_pkg::ACT_WRITE, 8'd128, -64'sd1, 0, 0, 0);
        push_cmd(strmq_pkg::ACT_WRITE, 8'd1,   64'sh5555_5555_5555_5555, 0, 0, 0);
        push_cmd(strmq_pkg::ACT_WRITE, 8'd254, 64'shAAAA_AAAA_AAAA_AAAA, 0, 0, 0);
        push_cmd(strmq_pkg::ACT_NOP,   8'd255, -64'sd1, -1, -1, 0);
        push_cmd(strmq_pkg::ACT_BUILD, 8'd0,   64'sd0, 0, 0, 0);
        push_cmd(strmq_pkg::ACT_QUERY, 8'd0,   64'sd0, -1024, 1023, 0);
        push_cmd(strmq_pkg::ACT_QUERY, 8'd0,   64'sd0, 0, 0, 0);
        push_cmd(strmq_pkg::ACT_QUERY, 8'd0,   64'sd0, 255, 255, 1);
        push_cmd(strmq_pkg::ACT_QUERY, 8'd0,   64'sd0, 1023, -1024, 0);
        push_cmd(strmq_pkg::ACT_QUERY, 8'd0,   64'sd0, 256, 300, 0);
        push_cmd(strmq_pkg::ACT_QUERY, 8'd0,   64'sd0, -5, -1, 0);
        push_cmd(strmq_pkg::ACT_QUERY, 8'd0,   64'sd0, 3, 2, 0);
        push_cmd(strmq_pkg::ACT_QUERY, 8'd0,   64'sd0, 1, 255, 0);
        push_cmd(strmq_pkg::ACT_QUERY, 8'd0,   64'sd0, 100, 227, 0);
        push_cmd(strmq_pkg::ACT_QUERY, 8'd0,   64'sd0, 129, 254, 0);
        push_cmd(strmq_pkg::ACT_WRITE, 8'd0,   64'sd5, 0, 0, 0);
        push_cmd(strmq_pkg::ACT_QUERY, 8'd0,   64'sd0, 0, 0, 0);
        push_cmd(strmq_pkg::ACT_BUILD, 8'd0,   64'sd0, 0, 0, 0);
        push_cmd(strmq_pkg::ACT_QUERY, 8'd0,   64'sd0, 0, 3, 0);
        push_cmd(strmq_pkg::ACT_QUERY, 8'd0,   64'sd0, -1, 0, 0);
        push_cmd(strmq_pkg::ACT_NOP,   8'd0,   64'sd0, 0, 0, 0);
        gen_built_n = 255;
        wait_idle();

        // random phases across several table sizes, some without idling
        for (ph = 0; ph < 10; ph++) begin
            idle_on = (ph % 3 != 1);
            load_last_index(8'(span_plan[ph]));
            queue_random_cmds(183);
            wait_idle();
        end

        if (mismatches == 0 && answers_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
